// ===== design/gmc_pkg.sv =====
// ----------------------------------------------------------------------------
// gmc_pkg - gate motor controller shared definitions
// Codes, state encodings, register indexes and reset values of the gate
// motor controller.
// ----------------------------------------------------------------------------
`default_nettype none

package gmc_pkg;

	// width of the travel counter; it saturates at its all-ones value
	localparam int unsigned TIMEOUT_WIDTH = 16;

	localparam int unsigned CFG_DATA_WIDTH  = 16;
	localparam int unsigned CFG_INDEX_WIDTH = 3;

	// register indexes on the configuration port
	localparam logic [CFG_INDEX_WIDTH-1:0] CFG_TRAVEL_TIMEOUT = 3'd0;
	localparam logic [CFG_INDEX_WIDTH-1:0] CFG_OPEN_BLINK     = 3'd1;
	localparam logic [CFG_INDEX_WIDTH-1:0] CFG_CLOSE_BLINK    = 3'd2;
	localparam logic [CFG_INDEX_WIDTH-1:0] CFG_ERROR_BLINK    = 3'd3;
	localparam logic [CFG_INDEX_WIDTH-1:0] CFG_BEEP           = 3'd4;
	localparam logic [CFG_INDEX_WIDTH-1:0] CFG_DEBOUNCE       = 3'd5;
	localparam logic [CFG_INDEX_WIDTH-1:0] CFG_LIMIT_LEVEL    = 3'd6;

	// register reset values
	localparam logic [15:0] RST_TRAVEL_TIMEOUT = 16'd240;
	localparam logic [7:0]  RST_OPEN_BLINK     = 8'd10;
	localparam logic [7:0]  RST_CLOSE_BLINK    = 8'd5;
	localparam logic [7:0]  RST_ERROR_BLINK    = 8'd10;
	localparam logic [7:0]  RST_BEEP           = 8'd2;
	localparam logic [7:0]  RST_DEBOUNCE       = 8'd2;
	localparam logic        RST_LIMIT_LEVEL    = 1'b1;

	typedef enum logic [2:0] {
		OP_TICK     = 3'd0,
		OP_OPEN     = 3'd1,
		OP_CLOSE    = 3'd2,
		OP_STOP     = 3'd3,
		OP_LAMP_ON  = 3'd4,
		OP_LAMP_OFF = 3'd5,
		OP_RESET    = 3'd6,
		OP_BOOT     = 3'd7
	} op_t;

	typedef enum logic [2:0] {
		DOOR_UNKNOWN = 3'd0,
		DOOR_CLOSED  = 3'd1,
		DOOR_OPENING = 3'd2,
		DOOR_OPEN    = 3'd3,
		DOOR_CLOSING = 3'd4,
		DOOR_ERROR   = 3'd5
	} door_state_t;

	typedef enum logic [1:0] {
		ERR_OK            = 2'd0,
		ERR_BOTH_LIMITS   = 2'd1,
		ERR_OPEN_TIMEOUT  = 2'd2,
		ERR_CLOSE_TIMEOUT = 2'd3
	} error_t;

	typedef enum logic [1:0] {
		DRV_STOP  = 2'd0,
		DRV_OPEN  = 2'd1,
		DRV_CLOSE = 2'd2
	} drive_t;

	typedef enum logic [3:0] {
		REQ_NONE          = 4'd0,
		REQ_BTN_OPEN      = 4'd1,
		REQ_BTN_CLOSE     = 4'd2,
		REQ_BTN_UNK_CLOSE = 4'd3,
		REQ_CMD_OPEN      = 4'd4,
		REQ_CMD_CLOSE     = 4'd5,
		REQ_STOP          = 4'd6,
		REQ_RESET         = 4'd7,
		REQ_BOOT          = 4'd8
	} request_t;

	typedef enum logic [2:0] {
		OUT_NONE          = 3'd0,
		OUT_OPENED        = 3'd1,
		OUT_CLOSED        = 3'd2,
		OUT_LIMITS        = 3'd3,
		OUT_OPEN_TIMEOUT  = 3'd4,
		OUT_CLOSE_TIMEOUT = 3'd5
	} outcome_t;

	// result item, packed lowest field in the lowest bits
	typedef struct packed {
		outcome_t    outcome_report;
		request_t    request_report;
		logic        buzzer_enable;
		logic        lamp;
		logic        drive_close;
		logic        drive_open;
		error_t      error_out;
		door_state_t door_state_out;
	} result_t;

endpackage

`default_nettype wire

// ===== design/gate_motor_controller.sv =====
// ----------------------------------------------------------------------------
// gate_motor_controller - gate opener with limit switches
// Door state machine with button debounce, travel timeout, lamp blink and
// error beeper, fed by tick and command items.
// ----------------------------------------------------------------------------
// Every input item (a tick or a command, selected by s_tuser) produces exactly
// one result item. The whole state update happens in the cycle the item is
// accepted, so the block takes one item per clock; the result sits in an
// output register backed by a one-entry skid stage, and s_tready drops only
// while both hold undelivered results. Counters and timing compare with >=,
// so a zero timing register fires on every tick. Write configuration only
// while no result is pending; writes to indexes beyond the list are ignored.
`default_nettype none

module gate_motor_controller (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// configuration port
	input  wire logic        cfg_we,
	input  wire logic [gmc_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
	input  wire logic [gmc_pkg::CFG_DATA_WIDTH-1:0]  cfg_data,
	// input items
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,  // button_level, open_limit_level, close_limit_level, zeros
	input  wire logic [2:0]  s_tuser,  // operation
	// result items
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [15:0]      m_tdata   // door_state_out[2:0], error_out[4:3], drive_open[5],
	                                   // drive_close[6], lamp[7], buzzer_enable[8],
	                                   // request_report[12:9], outcome_report[15:13]
);

	localparam int unsigned TW = gmc_pkg::TIMEOUT_WIDTH;

	// configuration registers
	logic [15:0] travel_timeout_q;
	logic [7:0]  open_blink_q;
	logic [7:0]  close_blink_q;
	logic [7:0]  error_blink_q;
	logic [7:0]  beep_ticks_q;
	logic [7:0]  debounce_q;
	logic        limit_level_q;

	// controller state
	gmc_pkg::door_state_t door_q, door_d;
	gmc_pkg::error_t      err_q, err_d;
	gmc_pkg::drive_t      drive_q, drive_d;
	logic [TW-1:0] travel_q, travel_d;
	logic [7:0]    blink_cnt_q, blink_cnt_d;
	logic          blink_phase_q, blink_phase_d;
	logic          lamp_q, lamp_d;
	logic          beep_phase_q, beep_phase_d;
	logic [7:0]    beep_cnt_q, beep_cnt_d;
	logic          buzzer_q, buzzer_d;
	logic [7:0]    stable_q, stable_d;
	logic          raw_prev_q, raw_prev_d;
	// the previous filtered level always equals the filtered level between
	// items, so one register serves both
	logic          filt_q, filt_d;

	// output register and skid stage
	gmc_pkg::result_t out_q, skid_q, res;
	logic             out_valid_q, skid_valid_q;

	logic        accept, take;
	gmc_pkg::op_t op;
	logic        btn, lim_open, lim_close;

	assign accept    = s_tvalid && s_tready;
	assign take      = m_tvalid && m_tready;
	assign s_tready  = !skid_valid_q;
	assign m_tvalid  = out_valid_q;
	assign m_tdata   = out_q;

	assign op        = gmc_pkg::op_t'(s_tuser);
	assign btn       = s_tdata[0];
	assign lim_open  = (s_tdata[1] == limit_level_q);
	assign lim_close = (s_tdata[2] == limit_level_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			travel_timeout_q <= gmc_pkg::RST_TRAVEL_TIMEOUT;
			open_blink_q     <= gmc_pkg::RST_OPEN_BLINK;
			close_blink_q    <= gmc_pkg::RST_CLOSE_BLINK;
			error_blink_q    <= gmc_pkg::RST_ERROR_BLINK;
			beep_ticks_q     <= gmc_pkg::RST_BEEP;
			debounce_q       <= gmc_pkg::RST_DEBOUNCE;
			limit_level_q    <= gmc_pkg::RST_LIMIT_LEVEL;
		end else if (cfg_we) begin
			case (cfg_index)
				gmc_pkg::CFG_TRAVEL_TIMEOUT: travel_timeout_q <= cfg_data;
				gmc_pkg::CFG_OPEN_BLINK:     open_blink_q     <= cfg_data[7:0];
				gmc_pkg::CFG_CLOSE_BLINK:    close_blink_q    <= cfg_data[7:0];
				gmc_pkg::CFG_ERROR_BLINK:    error_blink_q    <= cfg_data[7:0];
				gmc_pkg::CFG_BEEP:           beep_ticks_q     <= cfg_data[7:0];
				gmc_pkg::CFG_DEBOUNCE:       debounce_q       <= cfg_data[7:0];
				gmc_pkg::CFG_LIMIT_LEVEL:    limit_level_q    <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			door_q        <= gmc_pkg::DOOR_UNKNOWN;
			err_q         <= gmc_pkg::ERR_OK;
			drive_q       <= gmc_pkg::DRV_STOP;
			travel_q      <= '0;
			blink_cnt_q   <= '0;
			blink_phase_q <= 1'b0;
			lamp_q        <= 1'b0;
			beep_phase_q  <= 1'b0;
			beep_cnt_q    <= '0;
			buzzer_q      <= 1'b0;
			stable_q      <= '0;
			raw_prev_q    <= 1'b1;
			filt_q        <= 1'b1;
		end else if (accept) begin
			door_q        <= door_d;
			err_q         <= err_d;
			drive_q       <= drive_d;
			travel_q      <= travel_d;
			blink_cnt_q   <= blink_cnt_d;
			blink_phase_q <= blink_phase_d;
			lamp_q        <= lamp_d;
			beep_phase_q  <= beep_phase_d;
			beep_cnt_q    <= beep_cnt_d;
			buzzer_q      <= buzzer_d;
			stable_q      <= stable_d;
			raw_prev_q    <= raw_prev_d;
			filt_q        <= filt_d;
		end
	end

	always_comb begin
		logic              edge_hit;
		logic              opening;
		logic [7:0]        blink_limit;
		gmc_pkg::request_t req;
		gmc_pkg::outcome_t outc;

		door_d        = door_q;
		err_d         = err_q;
		drive_d       = drive_q;
		travel_d      = travel_q;
		blink_cnt_d   = blink_cnt_q;
		blink_phase_d = blink_phase_q;
		lamp_d        = lamp_q;
		beep_phase_d  = beep_phase_q;
		beep_cnt_d    = beep_cnt_q;
		buzzer_d      = buzzer_q;
		stable_d      = stable_q;
		raw_prev_d    = raw_prev_q;
		filt_d        = filt_q;
		edge_hit      = 1'b0;
		opening       = 1'b0;
		blink_limit   = error_blink_q;
		req           = gmc_pkg::REQ_NONE;
		outc          = gmc_pkg::OUT_NONE;

		case (op)
			gmc_pkg::OP_TICK: begin
				// debounce the raw button and look for a press
				if (btn == raw_prev_q) begin
					stable_d = stable_q + 8'd1;
				end else begin
					stable_d   = '0;
					raw_prev_d = btn;
				end
				if (stable_d >= debounce_q) begin
					filt_d   = btn;
					stable_d = '0;
				end
				edge_hit = filt_q && !filt_d;

				if (edge_hit) begin
					case (door_q)
						gmc_pkg::DOOR_CLOSED: begin
							door_d = gmc_pkg::DOOR_OPENING;
							req    = gmc_pkg::REQ_BTN_OPEN;
						end
						gmc_pkg::DOOR_OPEN: begin
							door_d = gmc_pkg::DOOR_CLOSING;
							req    = gmc_pkg::REQ_BTN_CLOSE;
						end
						gmc_pkg::DOOR_UNKNOWN: begin
							door_d = gmc_pkg::DOOR_CLOSING;
							req    = gmc_pkg::REQ_BTN_UNK_CLOSE;
						end
						default: ;
					endcase
				end

				// beeper: show the phase from before this tick's toggle
				if (door_d == gmc_pkg::DOOR_ERROR) begin
					beep_cnt_d = beep_cnt_q + 8'd1;
					buzzer_d   = beep_phase_q;
					if (beep_cnt_d >= beep_ticks_q) begin
						beep_cnt_d   = '0;
						beep_phase_d = !beep_phase_q;
					end
				end else begin
					buzzer_d     = 1'b0;
					beep_phase_d = 1'b0;
					beep_cnt_d   = '0;
				end

				opening     = (door_d == gmc_pkg::DOOR_OPENING);
				blink_limit = (door_d == gmc_pkg::DOOR_ERROR) ? error_blink_q :
				              (opening ? open_blink_q : close_blink_q);

				case (door_d)
					gmc_pkg::DOOR_OPENING, gmc_pkg::DOOR_CLOSING: begin
						if (lim_open && lim_close) begin
							door_d  = gmc_pkg::DOOR_ERROR;
							err_d   = gmc_pkg::ERR_BOTH_LIMITS;
							drive_d = gmc_pkg::DRV_STOP;
							outc    = gmc_pkg::OUT_LIMITS;
						end else begin
							drive_d = opening ? gmc_pkg::DRV_OPEN : gmc_pkg::DRV_CLOSE;
							if (travel_q != {TW{1'b1}}) begin
								travel_d = travel_q + TW'(1);
							end
							blink_cnt_d = blink_cnt_q + 8'd1;
							if (blink_cnt_d >= blink_limit) begin
								blink_cnt_d   = '0;
								blink_phase_d = !blink_phase_q;
								lamp_d        = blink_phase_d;
							end
							if (opening ? lim_open : lim_close) begin
								drive_d  = gmc_pkg::DRV_STOP;
								travel_d = '0;
								door_d   = opening ? gmc_pkg::DOOR_OPEN : gmc_pkg::DOOR_CLOSED;
								lamp_d   = opening;
								outc     = opening ? gmc_pkg::OUT_OPENED : gmc_pkg::OUT_CLOSED;
							end else if (32'(travel_d) >= 32'(travel_timeout_q)) begin
								drive_d = gmc_pkg::DRV_STOP;
								door_d  = gmc_pkg::DOOR_ERROR;
								err_d   = opening ? gmc_pkg::ERR_OPEN_TIMEOUT :
								                    gmc_pkg::ERR_CLOSE_TIMEOUT;
								outc    = opening ? gmc_pkg::OUT_OPEN_TIMEOUT :
								                    gmc_pkg::OUT_CLOSE_TIMEOUT;
							end
						end
					end
					gmc_pkg::DOOR_ERROR: begin
						drive_d     = gmc_pkg::DRV_STOP;
						blink_cnt_d = blink_cnt_q + 8'd1;
						if (blink_cnt_d >= blink_limit) begin
							blink_cnt_d   = '0;
							blink_phase_d = !blink_phase_q;
							lamp_d        = blink_phase_d;
						end
					end
					default: begin
						// idle: open keeps the lamp on, closed and unknown off
						lamp_d      = (door_d == gmc_pkg::DOOR_OPEN);
						drive_d     = gmc_pkg::DRV_STOP;
						blink_cnt_d = '0;
						travel_d    = '0;
					end
				endcase
			end
			gmc_pkg::OP_OPEN: begin
				if (door_q == gmc_pkg::DOOR_CLOSED || door_q == gmc_pkg::DOOR_UNKNOWN) begin
					door_d = gmc_pkg::DOOR_OPENING;
					req    = gmc_pkg::REQ_CMD_OPEN;
				end
			end
			gmc_pkg::OP_CLOSE: begin
				if (door_q == gmc_pkg::DOOR_OPEN || door_q == gmc_pkg::DOOR_UNKNOWN) begin
					door_d = gmc_pkg::DOOR_CLOSING;
					req    = gmc_pkg::REQ_CMD_CLOSE;
				end
			end
			gmc_pkg::OP_STOP: begin
				drive_d = gmc_pkg::DRV_STOP;
				door_d  = gmc_pkg::DOOR_UNKNOWN;
				req     = gmc_pkg::REQ_STOP;
			end
			gmc_pkg::OP_LAMP_ON:  lamp_d = 1'b1;
			gmc_pkg::OP_LAMP_OFF: lamp_d = 1'b0;
			gmc_pkg::OP_RESET: begin
				// motor keeps its drive until the next tick
				err_d  = gmc_pkg::ERR_OK;
				door_d = gmc_pkg::DOOR_UNKNOWN;
				req    = gmc_pkg::REQ_RESET;
			end
			default: begin
				// boot classify from the limit switches
				if (lim_open && lim_close) begin
					door_d = gmc_pkg::DOOR_ERROR;
					err_d  = gmc_pkg::ERR_BOTH_LIMITS;
				end else if (lim_open) begin
					door_d = gmc_pkg::DOOR_OPEN;
				end else if (lim_close) begin
					door_d = gmc_pkg::DOOR_CLOSED;
				end else begin
					door_d = gmc_pkg::DOOR_UNKNOWN;
				end
				req = gmc_pkg::REQ_BOOT;
			end
		endcase

		res.door_state_out = door_d;
		res.error_out      = err_d;
		res.drive_open     = (drive_d == gmc_pkg::DRV_OPEN);
		res.drive_close    = (drive_d == gmc_pkg::DRV_CLOSE);
		res.lamp           = lamp_d;
		res.buzzer_enable  = buzzer_d;
		res.request_report = req;
		res.outcome_report = outc;
	end

	// output register with skid stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (take) begin
				out_valid_q  <= skid_valid_q || accept;
				skid_valid_q <= 1'b0;
			end else if (accept) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= out_valid_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			if (skid_valid_q) begin
				out_q <= skid_q;
			end else if (accept) begin
				out_q <= res;
			end
		end else if (accept) begin
			if (out_valid_q) begin
				skid_q <= res;
			end else begin
				out_q <= res;
			end
		end
	end

	// a result arriving behind a stalled one must land in the skid stage
	a_skid_fill: assert property (@(posedge clk) disable iff (!arst_n)
		accept && out_valid_q && !m_tready |=> skid_valid_q)
		else $error("stalled result not held in skid stage");

	a_skid_needs_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid stage valid with empty output register");

	a_error_code: assert property (@(posedge clk) disable iff (!arst_n)
		door_q == gmc_pkg::DOOR_ERROR |-> err_q != gmc_pkg::ERR_OK)
		else $error("error state without an error code");

	a_one_direction: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(m_tdata[5] && m_tdata[6]))
		else $error("motor driven in both directions");

endmodule

`default_nettype wire

// ===== tb/sv/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench - gate motor controller
// Drives tick and command items into the gate controller and checks every
// result against a cycle-free predictor of the door machine, debounce,
// travel timeout, lamp blink and beeper. Runs directed cases first, then
// random door scenarios under several register settings and idling phases,
// and a long receiver hold-off that backs the block up to its input.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;

	localparam int unsigned CYCLE_LIMIT   = 400000;
	localparam int unsigned SETTLE_CYCLES = 4;
	localparam int unsigned HOLD_CYCLES   = 300;
	// cap on a random run of ticks, and on the travel limit a timeout run uses
	localparam int unsigned RUN_CAP       = 40;
	localparam logic [gmc_pkg::CFG_INDEX_WIDTH-1:0] CFG_UNUSED = 3'd7;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [gmc_pkg::CFG_INDEX_WIDTH-1:0] cfg_index = '0;
	logic [gmc_pkg::CFG_DATA_WIDTH-1:0]  cfg_data = '0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = '0;  // button_level, open_limit_level, close_limit_level, zeros
	logic [2:0]  s_tuser = '0;  // operation
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [15:0] m_tdata;       // door_state_out, error_out, drive_open, drive_close, lamp,
	                            // buzzer_enable, request_report, outcome_report

	gate_motor_controller dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	// predictor registers
	logic [15:0] t_travel_limit;
	logic [7:0]  t_open_blink, t_close_blink, t_err_blink, t_beep, t_debounce;
	logic        t_level;

	// predictor state
	gmc_pkg::door_state_t              g_state;
	gmc_pkg::error_t                   g_err;
	gmc_pkg::drive_t                   drive_q;
	logic [gmc_pkg::TIMEOUT_WIDTH-1:0] travel_cnt;
	logic [7:0]                        blink_cnt, beep_cnt, steady_cnt;
	logic                              blink_ph, lamp_q, beep_ph, buzz_q;
	logic                              raw_prev, btn_filt, btn_filt_prev;

	gmc_pkg::result_t expected_results[$];
	int unsigned items_sent = 0;
	int unsigned fail_count = 0;
	int unsigned cycle_count = 0;
	int unsigned tx_idle_pct = 0;
	int unsigned rx_stall_pct = 0;
	logic        hold_token = 1'b0;
	logic        hold_seen = 1'b0;
	int unsigned hold_left = 0;

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic logic rand_bit();
		return 1'($urandom_range(1));
	endfunction

	function automatic void gate_reset();
		t_travel_limit = gmc_pkg::RST_TRAVEL_TIMEOUT;
		t_open_blink = gmc_pkg::RST_OPEN_BLINK;
		t_close_blink = gmc_pkg::RST_CLOSE_BLINK;
		t_err_blink = gmc_pkg::RST_ERROR_BLINK;
		t_beep = gmc_pkg::RST_BEEP;
		t_debounce = gmc_pkg::RST_DEBOUNCE;
		t_level = gmc_pkg::RST_LIMIT_LEVEL;
		g_state = gmc_pkg::DOOR_UNKNOWN;
		g_err = gmc_pkg::ERR_OK;
		drive_q = gmc_pkg::DRV_STOP;
		travel_cnt = '0;
		blink_cnt = '0;
		beep_cnt = '0;
		steady_cnt = '0;
		blink_ph = 1'b0;
		lamp_q = 1'b0;
		beep_ph = 1'b0;
		buzz_q = 1'b0;
		raw_prev = 1'b1;
		btn_filt = 1'b1;
		btn_filt_prev = 1'b1;
	endfunction

	function automatic void advance_blink(logic [7:0] period);
		blink_cnt = blink_cnt + 8'd1;
		if (blink_cnt >= period) begin
			blink_cnt = '0;
			blink_ph = ~blink_ph;
			lamp_q = blink_ph;
		end
	endfunction

	function automatic void park(logic lamp_on);
		lamp_q = lamp_on;
		drive_q = gmc_pkg::DRV_STOP;
		blink_cnt = '0;
		travel_cnt = '0;
	endfunction

	// advance the predictor by one accepted item and return its result
	function automatic gmc_pkg::result_t gate_next(gmc_pkg::op_t op, logic btn,
			logic pin_open, logic pin_close);
		logic              at_open, at_close, press, opening;
		gmc_pkg::request_t req;
		gmc_pkg::outcome_t outc;
		gmc_pkg::result_t  r;
		at_open = (pin_open == t_level);
		at_close = (pin_close == t_level);
		req = gmc_pkg::REQ_NONE;
		outc = gmc_pkg::OUT_NONE;
		case (op)
			gmc_pkg::OP_TICK: begin
				if (btn == raw_prev) begin
					steady_cnt = steady_cnt + 8'd1;
				end else begin
					steady_cnt = '0;
					raw_prev = btn;
				end
				if (steady_cnt >= t_debounce) begin
					btn_filt = btn;
					steady_cnt = '0;
				end
				press = btn_filt_prev && !btn_filt;
				btn_filt_prev = btn_filt;
				if (press) begin
					case (g_state)
						gmc_pkg::DOOR_CLOSED: begin
							g_state = gmc_pkg::DOOR_OPENING;
							req = gmc_pkg::REQ_BTN_OPEN;
						end
						gmc_pkg::DOOR_OPEN: begin
							g_state = gmc_pkg::DOOR_CLOSING;
							req = gmc_pkg::REQ_BTN_CLOSE;
						end
						gmc_pkg::DOOR_UNKNOWN: begin
							g_state = gmc_pkg::DOOR_CLOSING;
							req = gmc_pkg::REQ_BTN_UNK_CLOSE;
						end
						default: ;
					endcase
				end
				// buzzer shows the phase from before this tick's toggle
				if (g_state == gmc_pkg::DOOR_ERROR) begin
					beep_cnt = beep_cnt + 8'd1;
					buzz_q = beep_ph;
					if (beep_cnt >= t_beep) begin
						beep_cnt = '0;
						beep_ph = ~beep_ph;
					end
				end else begin
					buzz_q = 1'b0;
					beep_ph = 1'b0;
					beep_cnt = '0;
				end
				case (g_state)
					gmc_pkg::DOOR_OPENING, gmc_pkg::DOOR_CLOSING: begin
						opening = (g_state == gmc_pkg::DOOR_OPENING);
						if (at_open && at_close) begin
							g_state = gmc_pkg::DOOR_ERROR;
							g_err = gmc_pkg::ERR_BOTH_LIMITS;
							drive_q = gmc_pkg::DRV_STOP;
							outc = gmc_pkg::OUT_LIMITS;
						end else begin
							drive_q = opening ? gmc_pkg::DRV_OPEN : gmc_pkg::DRV_CLOSE;
							if (travel_cnt != '1)
								travel_cnt = travel_cnt + 1'b1;
							advance_blink(opening ? t_open_blink : t_close_blink);
							if (opening ? at_open : at_close) begin
								drive_q = gmc_pkg::DRV_STOP;
								travel_cnt = '0;
								g_state = opening ? gmc_pkg::DOOR_OPEN : gmc_pkg::DOOR_CLOSED;
								lamp_q = opening;
								outc = opening ? gmc_pkg::OUT_OPENED : gmc_pkg::OUT_CLOSED;
							end else if (travel_cnt >= t_travel_limit) begin
								drive_q = gmc_pkg::DRV_STOP;
								g_state = gmc_pkg::DOOR_ERROR;
								g_err = opening ? gmc_pkg::ERR_OPEN_TIMEOUT :
									gmc_pkg::ERR_CLOSE_TIMEOUT;
								outc = opening ? gmc_pkg::OUT_OPEN_TIMEOUT :
									gmc_pkg::OUT_CLOSE_TIMEOUT;
							end
						end
					end
					gmc_pkg::DOOR_OPEN: park(1'b1);
					gmc_pkg::DOOR_ERROR: begin
						drive_q = gmc_pkg::DRV_STOP;
						advance_blink(t_err_blink);
					end
					default: park(1'b0);
				endcase
			end
			gmc_pkg::OP_OPEN: begin
				if (g_state == gmc_pkg::DOOR_CLOSED || g_state == gmc_pkg::DOOR_UNKNOWN) begin
					g_state = gmc_pkg::DOOR_OPENING;
					req = gmc_pkg::REQ_CMD_OPEN;
				end
			end
			gmc_pkg::OP_CLOSE: begin
				if (g_state == gmc_pkg::DOOR_OPEN || g_state == gmc_pkg::DOOR_UNKNOWN) begin
					g_state = gmc_pkg::DOOR_CLOSING;
					req = gmc_pkg::REQ_CMD_CLOSE;
				end
			end
			gmc_pkg::OP_STOP: begin
				drive_q = gmc_pkg::DRV_STOP;
				g_state = gmc_pkg::DOOR_UNKNOWN;
				req = gmc_pkg::REQ_STOP;
			end
			gmc_pkg::OP_LAMP_ON: lamp_q = 1'b1;
			gmc_pkg::OP_LAMP_OFF: lamp_q = 1'b0;
			gmc_pkg::OP_RESET: begin
				// motor keeps its drive until the next tick
				g_err = gmc_pkg::ERR_OK;
				g_state = gmc_pkg::DOOR_UNKNOWN;
				req = gmc_pkg::REQ_RESET;
			end
			default: begin
				if (at_open && at_close) begin
					g_state = gmc_pkg::DOOR_ERROR;
					g_err = gmc_pkg::ERR_BOTH_LIMITS;
				end else if (at_open) begin
					g_state = gmc_pkg::DOOR_OPEN;
				end else if (at_close) begin
					g_state = gmc_pkg::DOOR_CLOSED;
				end else begin
					g_state = gmc_pkg::DOOR_UNKNOWN;
				end
				req = gmc_pkg::REQ_BOOT;
			end
		endcase
		r.door_state_out = g_state;
		r.error_out = g_err;
		r.drive_open = (drive_q == gmc_pkg::DRV_OPEN);
		r.drive_close = (drive_q == gmc_pkg::DRV_CLOSE);
		r.lamp = lamp_q;
		r.buzzer_enable = buzz_q;
		r.request_report = req;
		r.outcome_report = outc;
		return r;
	endfunction

	function automatic logic pin(logic active);
		return active ? t_level : ~t_level;
	endfunction

	// offer one item, hold it until accepted, then predict its result
	task automatic send_item(gmc_pkg::op_t op, logic btn, logic pin_open, logic pin_close);
		if ($urandom_range(99) < tx_idle_pct) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tdata <= {5'b00000, pin_close, pin_open, btn};
		do @(posedge clk); while (!s_tready);
		expected_results.push_back(gate_next(op, btn, pin_open, pin_close));
		items_sent++;
	endtask

	task automatic send_tick(logic btn, logic act_open, logic act_close);
		send_item(gmc_pkg::OP_TICK, btn, pin(act_open), pin(act_close));
	endtask

	task automatic press_button();
		repeat (t_debounce + 1 + $urandom_range(0, 2)) send_tick(1'b0, 1'b0, 1'b0);
		repeat ($urandom_range(1, 3)) send_tick(1'b1, 1'b0, 1'b0);
	endtask

	task automatic wait_idle();
		s_tvalid <= 1'b0;
		while (expected_results.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic [gmc_pkg::CFG_INDEX_WIDTH-1:0] index, logic [15:0] value);
		cfg_we <= 1'b1;
		cfg_index <= index;
		cfg_data <= value;
		@(posedge clk);
		case (index)
			gmc_pkg::CFG_TRAVEL_TIMEOUT: t_travel_limit = value;
			gmc_pkg::CFG_OPEN_BLINK: t_open_blink = value[7:0];
			gmc_pkg::CFG_CLOSE_BLINK: t_close_blink = value[7:0];
			gmc_pkg::CFG_ERROR_BLINK: t_err_blink = value[7:0];
			gmc_pkg::CFG_BEEP: t_beep = value[7:0];
			gmc_pkg::CFG_DEBOUNCE: t_debounce = value[7:0];
			gmc_pkg::CFG_LIMIT_LEVEL: t_level = value[0];
			default: ;
		endcase
	endtask

	// junk puts random bits above each narrower register's width and writes the unused index
	task automatic load_registers(logic [15:0] timeout, logic [7:0] open_blink,
			logic [7:0] close_blink, logic [7:0] err_blink, logic [7:0] beep,
			logic [7:0] debounce, logic level, logic junk);
		logic [15:0] pad;
		pad = junk ? 16'($urandom) : 16'h0000;
		write_reg(gmc_pkg::CFG_TRAVEL_TIMEOUT, timeout);
		write_reg(gmc_pkg::CFG_OPEN_BLINK, {pad[15:8], open_blink});
		write_reg(gmc_pkg::CFG_CLOSE_BLINK, {pad[15:8], close_blink});
		write_reg(gmc_pkg::CFG_ERROR_BLINK, {pad[15:8], err_blink});
		write_reg(gmc_pkg::CFG_BEEP, {pad[15:8], beep});
		write_reg(gmc_pkg::CFG_DEBOUNCE, {pad[15:8], debounce});
		write_reg(gmc_pkg::CFG_LIMIT_LEVEL, {pad[15:1], level});
		if (junk)
			write_reg(CFG_UNUSED, pad);
		cfg_we <= 1'b0;
	endtask

	task automatic load_small_registers(logic level, logic junk);
		load_registers(16'($urandom_range(2, 12)), 8'($urandom_range(1, 6)),
			8'($urandom_range(1, 6)), 8'($urandom_range(1, 6)), 8'($urandom_range(1, 3)),
			8'($urandom_range(1, 3)), level, junk);
	endtask

	// mostly whole door sequences with random content, some noise
	task automatic random_items(int unsigned count);
		int unsigned stop_at, len;
		logic        go_open;
		stop_at = items_sent + count;
		while (items_sent < stop_at) begin
			case ($urandom_range(9))
				0, 1, 2: begin
					go_open = rand_bit();
					if ($urandom_range(1))
						send_item(go_open ? gmc_pkg::OP_OPEN : gmc_pkg::OP_CLOSE, rand_bit(),
							rand_bit(), rand_bit());
					else
						press_button();
					len = $urandom_range(0, ($urandom_range(3) == 0) ? 2 * t_open_blink + 2 : 12);
					if (len > RUN_CAP)
						len = RUN_CAP;
					repeat (len) send_tick(1'b1, 1'b0, 1'b0);
					case ($urandom_range(7))
						0: send_tick(1'b1, 1'b1, 1'b1);
						1: ; // leave it moving
						default: send_tick(rand_bit(), go_open, !go_open);
					endcase
				end
				3: press_button();
				4: begin
					// run into the travel timeout
					if (t_travel_limit <= RUN_CAP) begin
						send_item($urandom_range(1) ? gmc_pkg::OP_OPEN : gmc_pkg::OP_CLOSE, 1'b1,
							pin(1'b0), pin(1'b0));
						repeat (t_travel_limit + 1) send_tick(1'b1, 1'b0, 1'b0);
					end
				end
				5: begin
					send_item(gmc_pkg::OP_BOOT, rand_bit(), pin(1'b1), pin(1'b1));
					len = $urandom_range(0, ($urandom_range(3) == 0) ?
						t_err_blink + 2 * t_beep + 2 : 20);
					if (len > RUN_CAP)
						len = RUN_CAP;
					repeat (len) send_tick(1'b1, rand_bit(), rand_bit());
					case ($urandom_range(2))
						0: send_item(gmc_pkg::OP_STOP, rand_bit(), rand_bit(), rand_bit());
						1: send_item(gmc_pkg::OP_RESET, rand_bit(), rand_bit(), rand_bit());
						default: send_item(gmc_pkg::OP_BOOT, rand_bit(), rand_bit(),
							rand_bit());
					endcase
				end
				6, 7: send_item(gmc_pkg::op_t'($urandom_range(1, 7)), rand_bit(),
					rand_bit(), rand_bit());
				default: begin
					repeat ($urandom_range(1, 4))
						send_item(gmc_pkg::op_t'($urandom_range(7)), rand_bit(),
							rand_bit(), rand_bit());
				end
			endcase
		end
	endtask

	task automatic run_phase(int unsigned tx_pct, int unsigned rx_pct, int unsigned count);
		tx_idle_pct = tx_pct;
		rx_stall_pct <= rx_pct;
		random_items(count);
		wait_idle();
	endtask

	task automatic test_directed();
		tx_idle_pct = 0;
		send_item(gmc_pkg::OP_BOOT, 1'b1, pin(1'b0), pin(1'b0));
		send_item(gmc_pkg::OP_BOOT, 1'b1, pin(1'b1), pin(1'b0));
		send_item(gmc_pkg::OP_OPEN, 1'b1, pin(1'b0), pin(1'b0));   // ignored while open
		send_item(gmc_pkg::OP_CLOSE, 1'b1, pin(1'b0), pin(1'b0));
		send_tick(1'b1, 1'b0, 1'b0);
		send_tick(1'b1, 1'b0, 1'b1);
		send_item(gmc_pkg::OP_CLOSE, 1'b0, pin(1'b1), pin(1'b1));  // ignored while closed
		send_tick(1'b0, 1'b0, 1'b0);
		send_tick(1'b0, 1'b0, 1'b0);
		// button edge and open limit in the same tick
		send_tick(1'b0, 1'b1, 1'b0);
		send_tick(1'b1, 1'b0, 1'b0);
		send_item(gmc_pkg::OP_LAMP_OFF, 1'b0, pin(1'b0), pin(1'b0));
		send_item(gmc_pkg::OP_LAMP_ON, 1'b1, pin(1'b1), pin(1'b0));
		send_item(gmc_pkg::OP_BOOT, 1'b0, pin(1'b1), pin(1'b1));
		repeat (3) send_tick(1'b1, 1'b1, 1'b1);
		send_item(gmc_pkg::OP_STOP, 1'b1, pin(1'b0), pin(1'b0));   // keeps the error code
		send_item(gmc_pkg::OP_RESET, 1'b1, pin(1'b0), pin(1'b0));
		send_item(gmc_pkg::OP_OPEN, 1'b1, pin(1'b0), pin(1'b0));
		send_tick(1'b1, 1'b0, 1'b0);
		send_item(gmc_pkg::OP_RESET, 1'b1, pin(1'b0), pin(1'b0));  // drive held until next tick
		send_tick(1'b1, 1'b0, 1'b0);
		send_item(gmc_pkg::OP_CLOSE, 1'b1, pin(1'b0), pin(1'b0));
		send_tick(1'b1, 1'b1, 1'b1);
		wait_idle();
	endtask

	task automatic test_no_idling();
		load_registers(gmc_pkg::RST_TRAVEL_TIMEOUT, gmc_pkg::RST_OPEN_BLINK,
			gmc_pkg::RST_CLOSE_BLINK, gmc_pkg::RST_ERROR_BLINK, gmc_pkg::RST_BEEP,
			gmc_pkg::RST_DEBOUNCE, gmc_pkg::RST_LIMIT_LEVEL, 1'b0);
		run_phase(0, 0, 100);
	endtask

	task automatic test_sender_idle();
		load_small_registers(1'b0, 1'b0);
		run_phase(47, 0, 100);
	endtask

	task automatic test_receiver_stall();
		load_small_registers(1'b1, 1'b0);
		run_phase(0, 47, 100);
	endtask

	task automatic test_both_idle();
		load_small_registers(rand_bit(), 1'b1);
		run_phase(31, 31, 100);
	endtask

	task automatic test_zero_timing();
		load_registers(16'h0000, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0);
		run_phase(31, 31, 50);
	endtask

	// debounce stays short so button presses still fit in the phase
	task automatic test_max_timing();
		load_registers(16'hFFFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h03, 1'b1, 1'b0);
		run_phase(31, 31, 50);
	endtask

	// hold the receiver off while items keep coming so the block backs up
	task automatic test_backpressure();
		load_small_registers(1'b1, 1'b0);
		tx_idle_pct = 0;
		rx_stall_pct <= 0;
		hold_token <= ~hold_token;
		repeat (40) send_item(gmc_pkg::op_t'($urandom_range(7)), rand_bit(),
			rand_bit(), rand_bit());
		wait_idle();
	endtask

	// hold-off counter for the long receiver stall
	always @(posedge clk) begin
		if (hold_token != hold_seen) begin
			hold_seen <= hold_token;
			hold_left <= HOLD_CYCLES;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end
	end

	// receiver: pace m_tready and check each result against the oldest prediction
	always @(posedge clk) begin
		gmc_pkg::result_t got, want;
		if (arst_n && m_tvalid && m_tready) begin
			got = gmc_pkg::result_t'(m_tdata);
			if (expected_results.size() == 0) begin
				$error("unexpected result item %h", m_tdata);
				fail_count++;
			end else begin
				want = expected_results.pop_front();
				if (got.door_state_out !== want.door_state_out) begin
					$error("door_state_out: expected %0d, got %0d",
						want.door_state_out, got.door_state_out);
					fail_count++;
				end
				if (got.error_out !== want.error_out) begin
					$error("error_out: expected %0d, got %0d", want.error_out, got.error_out);
					fail_count++;
				end
				if (got.drive_open !== want.drive_open) begin
					$error("drive_open: expected %0d, got %0d", want.drive_open, got.drive_open);
					fail_count++;
				end
				if (got.drive_close !== want.drive_close) begin
					$error("drive_close: expected %0d, got %0d",
						want.drive_close, got.drive_close);
					fail_count++;
				end
				if (got.lamp !== want.lamp) begin
					$error("lamp: expected %0d, got %0d", want.lamp, got.lamp);
					fail_count++;
				end
				if (got.buzzer_enable !== want.buzzer_enable) begin
					$error("buzzer_enable: expected %0d, got %0d",
						want.buzzer_enable, got.buzzer_enable);
					fail_count++;
				end
				if (got.request_report !== want.request_report) begin
					$error("request_report: expected %0d, got %0d",
						want.request_report, got.request_report);
					fail_count++;
				end
				if (got.outcome_report !== want.outcome_report) begin
					$error("outcome_report: expected %0d, got %0d",
						want.outcome_report, got.outcome_report);
					fail_count++;
				end
			end
		end
		if (hold_token != hold_seen || hold_left != 0) begin
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= rx_stall_pct);
		end
	end

	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("testbench: errors");
		$finish;
	end

	initial begin
		gate_reset();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_no_idling();
		test_sender_idle();
		test_receiver_stall();
		test_both_idle();
		test_zero_timing();
		test_max_timing();
		test_backpressure();
		if (fail_count == 0 && expected_results.size() == 0)
			$display("testbench: clean");
		else
			$display("testbench: errors");
		$finish;
	end

endmodule

`default_nettype wire

// ===== gate_motor_controller.f =====
design/gmc_pkg.sv
design/gate_motor_controller.sv
tb/sv/testbench.sv
